@@ sv/iap_pkg.sv @@
// Shared types, constants and helpers for the integer-to-padded-ASCII renderer.
package iap_pkg;

  localparam logic [1:0] CONV_SDEC = 2'd0;
  localparam logic [1:0] CONV_UDEC = 2'd1;
  localparam logic [1:0] CONV_HEXL = 2'd2;
  localparam logic [1:0] CONV_HEXU = 2'd3;

  localparam logic [5:0] MAX_WIDTH = 6'd63;
  localparam int         NUM_DIGITS = 10;

  // floor(n / 10) == (n * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit n
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER_BASE = 8'h37;  // 'A' - 10
  localparam logic [7:0] CH_LOWER_BASE = 8'h57;  // 'a' - 10

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  conversion;
    logic [5:0]  field_width;
    logic        zero_pad;
    logic        left_justify;
    logic        plus_sign;
    logic        space_sign;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } out_item_t;

  // Rendered field, ready for the back end to stream out
  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digits;
    logic [3:0]                 ndigits;
    logic                       has_sign;
    logic [7:0]                 sign_char;
    logic                       upper;
    logic [5:0]                 pre_pad;
    logic [5:0]                 mid_pad;
    logic [5:0]                 post_pad;
  } desc_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PRE,
    B_SIGN,
    B_MID,
    B_DIG,
    B_POST
  } back_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'h0, d};
    end else begin
      r = (upper ? CH_UPPER_BASE : CH_LOWER_BASE) + {4'h0, d};
    end
    return r;
  endfunction

endpackage

@@ sv/iap_front.sv @@
// Front end: takes an item, finds sign and magnitude, converts to digits, works out padding.
module iap_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              operand_valid,
  output logic              operand_stall,
  input  iap_pkg::in_item_t operand,
  output logic              push,
  output iap_pkg::desc_t    push_desc,
  input  logic              full
);
  import iap_pkg::*;

  front_state_t               fstate, fstate_next;
  logic [31:0]                shreg;
  logic [NUM_DIGITS-1:0][3:0] bcd;
  logic [NUM_DIGITS-1:0][3:0] bcd_next;
  logic [3:0]                 dig_cnt;
  logic                       has_sign;
  logic [7:0]                 sign_char;
  logic [5:0]                 width_sat;
  logic                       left;
  logic                       zero;
  logic                       upper;

  logic        accept;
  logic        neg;
  logic [31:0] mag;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [3:0]  rem;
  logic [3:0]  nd;
  logic [3:0]  len;
  logic [5:0]  pad;

  assign accept = operand_valid && !operand_stall;
  assign neg    = (operand.conversion == CONV_SDEC) && operand.value[31];
  assign mag    = neg ? (32'd0 - operand.value) : operand.value;

  // one decimal step: divide by ten through the reciprocal, the remainder is the
  // next digit up and enters at the top, so the lowest digit ends at index 0
  always_comb begin
    prod     = {32'd0, shreg} * {32'd0, DIV10_RECIP};
    quot     = {3'b000, prod[63:DIV10_SHIFT]};
    rem      = shreg[3:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};
    bcd_next = {rem, bcd[NUM_DIGITS-1:1]};
  end

  // digit count: highest non-zero digit, at least one
  always_comb begin
    nd = 4'd1;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd[i] != 4'd0) nd = 4'(i + 1);
    end
  end

  assign len = nd + {3'b0, has_sign};
  assign pad = (width_sat > {2'b0, len}) ? (width_sat - {2'b0, len}) : 6'd0;

  always_comb begin
    push_desc.digits    = bcd;
    push_desc.ndigits   = nd;
    push_desc.has_sign  = has_sign;
    push_desc.sign_char = sign_char;
    push_desc.upper     = upper;
    push_desc.pre_pad   = (!left && !zero) ? pad : 6'd0;
    push_desc.mid_pad   = (!left && zero) ? pad : 6'd0;
    push_desc.post_pad  = left ? pad : 6'd0;
  end

  always_comb begin
    fstate_next = fstate;
    case (fstate)
      F_IDLE: begin
        if (accept) begin
          fstate_next = (operand.conversion inside {CONV_SDEC, CONV_UDEC}) ? F_CONV : F_PUSH;
        end
      end
      F_CONV: begin
        if (dig_cnt == 4'(NUM_DIGITS - 1)) fstate_next = F_PUSH;
      end
      F_PUSH: begin
        if (!full) fstate_next = F_IDLE;
      end
      default: fstate_next = F_IDLE;
    endcase
  end

  always_comb begin
    operand_stall = (fstate != F_IDLE);
    push          = (fstate == F_PUSH) && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      fstate <= fstate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg     <= mag;
      dig_cnt   <= 4'd0;
      upper     <= (operand.conversion == CONV_HEXU);
      left      <= operand.left_justify;
      zero      <= operand.zero_pad;
      width_sat <= (operand.field_width > MAX_WIDTH) ? MAX_WIDTH : operand.field_width;
      if (operand.conversion inside {CONV_SDEC, CONV_UDEC}) begin
        bcd <= '0;
      end else begin
        bcd <= {8'h00, mag};
      end
      if (neg) begin
        has_sign  <= 1'b1;
        sign_char <= CH_MINUS;
      end else if ((operand.conversion == CONV_SDEC) && operand.plus_sign) begin
        has_sign  <= 1'b1;
        sign_char <= CH_PLUS;
      end else if ((operand.conversion == CONV_SDEC) && operand.space_sign) begin
        has_sign  <= 1'b1;
        sign_char <= CH_SPACE;
      end else begin
        has_sign  <= 1'b0;
        sign_char <= CH_SPACE;
      end
    end else if (fstate == F_CONV) begin
      bcd     <= bcd_next;
      shreg   <= quot;
      dig_cnt <= dig_cnt + 4'd1;
    end
  end

endmodule

@@ sv/iap_queue.sv @@
// Short queue of rendered field descriptors between front and back end.
module iap_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  iap_pkg::desc_t push_desc,
  input  logic           pop,
  output iap_pkg::desc_t head,
  output logic           empty,
  output logic           full
);
  import iap_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == CNT_W'(0));
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/iap_back.sv @@
// Back end: streams a descriptor to the output register, one char per cycle unless stalled.
module iap_back (
  input  logic               clk,
  input  logic               rst,
  input  iap_pkg::desc_t     head,
  input  logic               empty,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output iap_pkg::out_item_t result
);
  import iap_pkg::*;

  back_state_t                state, state_next;
  logic [NUM_DIGITS-1:0][3:0] digits;
  logic [3:0]                 didx;
  logic                       has_sign;
  logic [7:0]                 sign_char;
  logic                       upper;
  logic [5:0]                 pre_cnt;
  logic [5:0]                 mid_cnt;
  logic [5:0]                 post_cnt;

  logic        emit;
  logic        last;
  logic        load;
  logic [7:0]  ch;
  back_state_t first_phase;

  assign emit = (state != B_IDLE) && (!result_valid || !result_stall);

  always_comb begin
    if (head.pre_pad != 6'd0) begin
      first_phase = B_PRE;
    end else if (head.has_sign) begin
      first_phase = B_SIGN;
    end else if (head.mid_pad != 6'd0) begin
      first_phase = B_MID;
    end else begin
      first_phase = B_DIG;
    end
  end

  // outputs of the sequencer
  always_comb begin
    ch   = CH_SPACE;
    last = 1'b0;
    case (state)
      B_PRE:  ch = CH_SPACE;
      B_SIGN: ch = sign_char;
      B_MID:  ch = CH_ZERO;
      B_DIG: begin
        ch   = digit_char(digits[didx], upper);
        last = (didx == 4'd0) && (post_cnt == 6'd0);
      end
      B_POST: begin
        ch   = CH_SPACE;
        last = (post_cnt == 6'd1);
      end
      default: ch = CH_SPACE;
    endcase
    load = !empty && ((state == B_IDLE) || (emit && last));
    pop  = load;
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty) state_next = first_phase;
      end
      B_PRE: begin
        if (emit && pre_cnt == 6'd1) begin
          state_next = has_sign ? B_SIGN : ((mid_cnt != 6'd0) ? B_MID : B_DIG);
        end
      end
      B_SIGN: begin
        if (emit) state_next = (mid_cnt != 6'd0) ? B_MID : B_DIG;
      end
      B_MID: begin
        if (emit && mid_cnt == 6'd1) state_next = B_DIG;
      end
      B_DIG: begin
        if (emit && didx == 4'd0) begin
          if (post_cnt != 6'd0) begin
            state_next = B_POST;
          end else begin
            state_next = empty ? B_IDLE : first_phase;
          end
        end
      end
      B_POST: begin
        if (emit && post_cnt == 6'd1) state_next = empty ? B_IDLE : first_phase;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.character <= ch;
      result.last_char <= last;
    end
    if (load) begin
      digits    <= head.digits;
      didx      <= head.ndigits - 4'd1;
      has_sign  <= head.has_sign;
      sign_char <= head.sign_char;
      upper     <= head.upper;
      pre_cnt   <= head.pre_pad;
      mid_cnt   <= head.mid_pad;
      post_cnt  <= head.post_pad;
    end else if (emit) begin
      case (state)
        B_PRE:   pre_cnt  <= pre_cnt - 6'd1;
        B_MID:   mid_cnt  <= mid_cnt - 6'd1;
        B_DIG:   didx     <= (didx == 4'd0) ? didx : didx - 4'd1;
        B_POST:  post_cnt <= post_cnt - 6'd1;
        default: pre_cnt  <= pre_cnt;
      endcase
    end
  end

  a_sign_phase_has_sign: assert property (@(posedge clk) disable iff (rst)
    (state == B_SIGN) |-> has_sign)
    else $error("sign phase entered without a sign");

  a_mid_cnt_live: assert property (@(posedge clk) disable iff (rst)
    (state == B_MID) |-> (mid_cnt != 6'd0))
    else $error("zero-pad phase with empty count");

  a_post_cnt_live: assert property (@(posedge clk) disable iff (rst)
    (state == B_POST) |-> (post_cnt != 6'd0))
    else $error("trailing pad phase with empty count");

  a_pre_cnt_live: assert property (@(posedge clk) disable iff (rst)
    (state == B_PRE) |-> (pre_cnt != 6'd0))
    else $error("leading pad phase with empty count");

endmodule

@@ sv/integer_to_padded_ascii.sv @@
// Top level of the integer-to-padded-ASCII renderer (%d, %u, %x, %X style fields).
// Hex items go straight to the queue; decimal items first take 10 divide-by-ten steps.
// The front end takes no new item until the current one is pushed to the queue;
// the back end sends one character per cycle while the sink does not stall.
// The sustained rate is the slower of the two: the decimal converter or the field length.
// Reset (rst, synchronous) empties the queue and idles both ends; no clearing pass.
module integer_to_padded_ascii #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               operand_valid,
  output logic               operand_stall,
  input  iap_pkg::in_item_t  operand,
  output logic               result_valid,
  input  logic               result_stall,
  output iap_pkg::out_item_t result
);
  import iap_pkg::*;

  // front end to queue
  logic  push;
  desc_t push_desc;
  logic  full;

  // queue to back end
  desc_t head;
  logic  empty;
  logic  pop;

  // Front: accepts an item, derives sign and magnitude, peels off decimal digits
  // by one divide-by-ten step a cycle, then works out the three pad counts.
  iap_front u_front (
    .clk           (clk),
    .rst           (rst),
    .operand_valid (operand_valid),
    .operand_stall (operand_stall),
    .operand       (operand),
    .push          (push),
    .push_desc     (push_desc),
    .full          (full)
  );

  // Queue: lets the front convert the next item while the back streams the last.
  iap_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // Back: leading spaces, sign, zeros, digits, trailing spaces, one per cycle,
  // through an output register that holds while the sink stalls.
  iap_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ tb/sv/tb.sv @@
// Testbench for integer_to_padded_ascii: self-checking printf-style field rendering.
`timescale 1ns / 100ps

module tb;
  import iap_pkg::*;

  // Expected characters per accepted operand, checked in order as they leave
  class field_scoreboard;
    out_item_t   pending_chars[$];
    int unsigned operands_seen;
    int unsigned chars_checked;
    int unsigned mismatches;

    // Works out the full rendered field of one operand and queues it
    function void note_operand(input in_item_t op);
      logic [7:0]  field_text[$];
      logic [7:0]  digit_text[$];
      logic [7:0]  sign_char;
      logic [31:0] mag;
      logic [5:0]  width;
      logic [3:0]  d;
      int unsigned base;
      int unsigned len;
      out_item_t   c;
      operands_seen++;
      width = (op.field_width > MAX_WIDTH) ? MAX_WIDTH : op.field_width;
      sign_char = 8'h00;
      mag = op.value;
      base = (op.conversion == CONV_HEXL || op.conversion == CONV_HEXU) ? 16 : 10;
      // sign only ever appears for signed decimal
      if (op.conversion == CONV_SDEC) begin
        if (op.value[31]) begin
          sign_char = "-";
          mag = 32'd0 - op.value;
        end else if (op.plus_sign) begin
          sign_char = "+";
        end else if (op.space_sign) begin
          sign_char = " ";
        end
      end
      do begin
        d = 4'(mag % base);
        if (d < 4'd10) begin
          digit_text.push_front(8'("0") + 8'(d));
        end else if (op.conversion == CONV_HEXU) begin
          digit_text.push_front(8'("A") + 8'(d) - 8'd10);
        end else begin
          digit_text.push_front(8'("a") + 8'(d) - 8'd10);
        end
        mag = mag / base;
      end while (mag != 0);
      len = digit_text.size() + ((sign_char != 8'h00) ? 1 : 0);
      // zero fill sits between sign and digits; left justify wins over it
      if (!op.left_justify && op.zero_pad && width > len) begin
        if (sign_char != 8'h00) field_text.push_back(sign_char);
        for (int i = len; i < width; i++) field_text.push_back("0");
        sign_char = 8'h00;
      end else if (!op.left_justify) begin
        for (int i = len; i < width; i++) field_text.push_back(" ");
      end
      if (sign_char != 8'h00) field_text.push_back(sign_char);
      foreach (digit_text[i]) field_text.push_back(digit_text[i]);
      if (op.left_justify) begin
        for (int i = len; i < width; i++) field_text.push_back(" ");
      end
      foreach (field_text[i]) begin
        c.character = field_text[i];
        c.last_char = (i == field_text.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(input out_item_t got);
      out_item_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, got %h last %b",
                 $time, got.character, got.last_char);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      chars_checked++;
      if (got.character !== want.character) begin
        $display("%0t: character mismatch: expected %h, got %h",
                 $time, want.character, got.character);
        mismatches++;
      end
      if (got.last_char !== want.last_char) begin
        $display("%0t: last_char mismatch: expected %b, got %b",
                 $time, want.last_char, got.last_char);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      operand_valid = 1'b0;
  logic      operand_stall;
  in_item_t  operand = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  field_scoreboard sb = new();

  // idling odds in percent, changed per phase by the main sequence
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_request = 1'b0;

  integer_to_padded_ascii u_dut (
    .clk           (clk),
    .rst           (rst),
    .operand_valid (operand_valid),
    .operand_stall (operand_stall),
    .operand       (operand),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // reset held from the start and released once only
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Generous limit: even every field at full width behind a stalling receiver
  // finishes well inside this
  initial begin
    #5_000_000;
    $display("Run timed out with %0d characters still awaited", sb.pending_chars.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic in_item_t make_operand(input logic [31:0] v, input logic [1:0] conv,
                                            input logic [5:0] w, input logic zp,
                                            input logic lj, input logic ps,
                                            input logic ss);
    in_item_t op;
    op.value = v;
    op.conversion = conv;
    op.field_width = w;
    op.zero_pad = zp;
    op.left_justify = lj;
    op.plus_sign = ps;
    op.space_sign = ss;
    return op;
  endfunction

  // Mostly short fields; every tenth or so takes any width up to the maximum
  function automatic in_item_t random_operand();
    in_item_t op;
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1:    v = $urandom;
      2:       v = $urandom >> $urandom_range(0, 31);
      3:       v = 32'd0 - ($urandom >> $urandom_range(0, 31));
      4:       v = $urandom_range(0, 20);
      default: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h0000_0000;
          1:       v = 32'h8000_0000;
          2:       v = 32'h7fff_ffff;
          3:       v = 32'hffff_ffff;
          default: v = 32'h0000_0001;
        endcase
      end
    endcase
    op.value = v;
    op.conversion = 2'($urandom_range(0, 3));
    op.field_width = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 14));
    {op.zero_pad, op.left_justify, op.plus_sign, op.space_sign} = 4'($urandom);
    return op;
  endfunction

  task automatic send_operand(input in_item_t op);
    operand <= op;
    operand_valid <= 1'b1;
    do @(posedge clk); while (operand_stall);
    sb.note_operand(op);
  endtask

  // geometric run of idle cycles before the next item
  task automatic idle_gap();
    int n;
    n = 0;
    while ($urandom_range(0, 99) < sender_idle_pct && n < 20) n++;
    if (n > 0) begin
      operand_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Result side: check each accepted character, then pick the next stall
  initial begin
    int hold_left;
    hold_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (result_valid && !result_stall) sb.check_char(result);
      if (hold_request) begin
        hold_left = 400;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    in_item_t    directed_ops[$];
    int unsigned phase_idle[4];
    int unsigned phase_stall[4];
    int          waited;
    phase_idle  = '{0, 64, 0, 25};
    phase_stall = '{0, 0, 64, 25};

    // extremes, every conversion, sign rules, zero value, most negative,
    // short fields and full-width fields
    directed_ops.push_back(make_operand(32'h0000_0000, CONV_SDEC, 6'd0, 0, 0, 0, 0));
    directed_ops.push_back(make_operand(32'h8000_0000, CONV_SDEC, 6'd0, 0, 0, 0, 0));
    directed_ops.push_back(make_operand(32'h7fff_ffff, CONV_SDEC, 6'd0, 0, 0, 1, 0));
    directed_ops.push_back(make_operand(32'hffff_ffff, CONV_SDEC, 6'd8, 1, 0, 0, 0));
    directed_ops.push_back(make_operand(32'd42, CONV_SDEC, 6'd6, 1, 0, 0, 1));
    directed_ops.push_back(make_operand(32'd42, CONV_SDEC, 6'd10, 0, 1, 1, 1));
    directed_ops.push_back(make_operand(32'h0000_0000, CONV_SDEC, 6'd0, 0, 0, 0, 1));
    directed_ops.push_back(make_operand(32'hffff_ffff, CONV_UDEC, 6'd0, 0, 0, 0, 0));
    directed_ops.push_back(make_operand(32'd123, CONV_UDEC, 6'd8, 0, 0, 1, 1));
    directed_ops.push_back(make_operand(32'h0000_0000, CONV_UDEC, 6'd1, 1, 0, 0, 0));
    directed_ops.push_back(make_operand(32'hdead_beef, CONV_HEXL, 6'd12, 1, 0, 1, 0));
    directed_ops.push_back(make_operand(32'hdead_beef, CONV_HEXU, 6'd63, 0, 1, 0, 1));
    directed_ops.push_back(make_operand(32'h0000_0000, CONV_HEXU, 6'd63, 1, 0, 0, 0));
    directed_ops.push_back(make_operand(32'hffff_fffb, CONV_SDEC, 6'd63, 1, 0, 1, 0));
    directed_ops.push_back(make_operand(32'd7, CONV_UDEC, 6'd63, 0, 0, 0, 0));
    directed_ops.push_back(make_operand(32'h8000_0000, CONV_SDEC, 6'd5, 1, 0, 0, 0));
    directed_ops.push_back(make_operand(32'habcd_ef01, CONV_HEXL, 6'd3, 1, 1, 0, 0));
    directed_ops.push_back(make_operand(32'd17, CONV_SDEC, 6'd1, 1, 0, 0, 0));
    directed_ops.push_back(make_operand(32'h0000_000f, CONV_HEXU, 6'd2, 1, 0, 0, 0));
    directed_ops.push_back(make_operand(32'hffff_ff85, CONV_SDEC, 6'd10, 1, 1, 0, 0));
    directed_ops.push_back(make_operand(32'hffff_ffff, CONV_HEXL, 6'd63, 1, 1, 1, 1));

    wait (rst == 1'b0);
    @(posedge clk);

    foreach (directed_ops[i]) send_operand(directed_ops[i]);

    // four idling phases of random operands; the first starts with a long
    // receiver hold-off so the queue fills and the input backs up
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 0) hold_request = 1'b1;
      repeat (75) begin
        idle_gap();
        send_operand(random_operand());
      end
    end
    operand_valid <= 1'b0;

    // drain, then keep watching so any unexpected extra character is flagged
    waited = 0;
    while (sb.pending_chars.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);

    if (sb.pending_chars.size() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, sb.pending_chars.size());
      sb.mismatches++;
    end

    $display("Rendered %0d operands (directed corners, then random across four idling phases)",
             sb.operands_seen);
    $display("Checked %0d characters with %0d mismatches", sb.chars_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
